[src/tvpw_pkg.sv]
// Shared types and constants for the text video memory plane write unit.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none
package tvpw_pkg;

    // Memory geometry. PLANE_BYTES and LINE_COUNT are powers of two.
    localparam int PLANE_BYTES = 131072;
    localparam int LINE_COUNT  = 1024;
    localparam int PLANES      = 4;
    localparam int OFF_W       = $clog2(PLANE_BYTES);
    localparam int LINE_W      = $clog2(LINE_COUNT);

    // Fixed field widths of the transaction payloads.
    localparam int ADDR_W   = 19;
    localparam int DLINE_W  = 10;
    localparam int GROUP_W  = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;

    // Mask that reduces a line number modulo LINE_COUNT.
    localparam logic [DLINE_W-1:0] LINE_MASK = DLINE_W'(LINE_COUNT - 1);

    // Command codes.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SIMULTANEOUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_ENABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_SELECT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_EVEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_ODD     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y     = 3'd5;

    // Request payload.
    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] address;
        logic [7:0]        write_data;
    } req_t;

    // Response payload.
    typedef struct packed {
        logic [7:0]         read_data;
        logic               line_dirty;
        logic [DLINE_W-1:0] dirty_line;
        logic               pixels_valid;
        logic [GROUP_W-1:0] pixel_group;
        logic [31:0]        pixels;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic capture;
        logic read_en;
        logic commit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
    } ctrl_sts_t;

endpackage
`default_nettype wire

[src/text_vram_plane_write_unit.sv]
// Top level of the text video memory plane write unit.
// Depends on tvpw_pkg, tvpw_ctrl, tvpw_datapath and tvpw_plane_ram.
//
// Usage:
//  - Request channel (req_valid, req_stall, req) carries byte reads and writes.
//    A transaction is accepted when req_valid is high and req_stall is low.
//  - Response channel (rsp_valid, rsp_stall, rsp) returns one result per
//    request, in order; the receiver holds rsp_stall high to keep it.
//  - Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
//    one register per transaction; cfg_ready is always high.
//  - Sequencing: an accepted request passes through a read state, which reads
//    all four planes, and a write state, which writes them back and loads the
//    result register; the next request can be accepted as the current one commits.
//  - A waiting result does not block acceptance; the write-back cycle waits
//    only while the result register is full and rsp_stall is high.
//  - After reset a clearing pass zeroes the planes, one offset of all four
//    planes per cycle over all 131072 offsets; req_stall stays high meanwhile.
`default_nettype none
module text_vram_plane_write_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire tvpw_pkg::req_t                    req,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_stall,
    output tvpw_pkg::rsp_t                         rsp,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tvpw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tvpw_pkg::CFG_DAT_W-1:0]    cfg_data
);

    tvpw_pkg::ctrl_cmd_t cmd;
    tvpw_pkg::ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    // Sequencer.
    tvpw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Memories and result logic.
    tvpw_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // No request enters during the clearing pass.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> req_stall)
        else $error("request accepted during clearing pass");

    // Each transaction reads the planes once: no read follows a read in the next cycle.
    a_single_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_en |=> !cmd.read_en)
        else $error("plane read issued twice in a row");

    // After a read phase, a new request is captured only as the current one commits.
    a_commit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_en |=> !cmd.capture || cmd.commit)
        else $error("request captured before previous one committed");

    // Dirty marking only comes with a write result.
    a_dirty_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.line_dirty) |-> rsp.pixels_valid && (rsp.read_data == 8'd0))
        else $error("dirty line reported on a read result");

endmodule
`default_nettype wire

[src/tvpw_plane_ram.sv]
// One bit plane of video memory: one write port and one registered read port.
// Depends on tvpw_pkg for the plane depth.
`default_nettype none
module tvpw_plane_ram (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [tvpw_pkg::OFF_W-1:0] waddr,
    input  wire logic [7:0]               wdata,
    input  wire logic                     re,
    input  wire logic [tvpw_pkg::OFF_W-1:0] raddr,
    output logic      [7:0]               rdata
);

    logic [7:0] mem [tvpw_pkg::PLANE_BYTES];
    logic [7:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[src/tvpw_ctrl.sv]
// Controller: clearing pass after reset, then read and write phases per transaction.
// Depends on tvpw_pkg for the command and status structs.
`default_nettype none
module tvpw_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    input  wire tvpw_pkg::ctrl_sts_t sts,
    output tvpw_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    logic   accept;

    // The output register can take a result when empty or emptying now.
    assign slot_free = !out_valid_reg || !rsp_stall;

    // A new transaction enters when idle or when the current one commits.
    assign req_stall = !((state_reg == ST_IDLE) ||
                         ((state_reg == ST_WRITE) && slot_free));
    assign accept    = req_valid && !req_stall;

    // Commands to the datapath.
    always_comb
    begin
        cmd.clear   = (state_reg == ST_CLEAR);
        cmd.capture = accept;
        cmd.read_en = (state_reg == ST_READ);
        cmd.commit  = (state_reg == ST_WRITE) && slot_free;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (slot_free)
                begin
                    state_next = accept ? ST_READ : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Output valid flag follows commits and taken results.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule
`default_nettype wire

[src/tvpw_datapath.sv]
// Datapath: configuration registers, four plane memories, merge logic and result register.
// Depends on tvpw_pkg and tvpw_plane_ram.
`default_nettype none
module tvpw_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tvpw_pkg::req_t                    req,
    output tvpw_pkg::rsp_t                         rsp,
    input  wire logic                              cfg_we,
    input  wire logic [tvpw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tvpw_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  wire tvpw_pkg::ctrl_cmd_t               cmd,
    output tvpw_pkg::ctrl_sts_t                    sts
);

    localparam int OFF_W  = tvpw_pkg::OFF_W;
    localparam int PLANES = tvpw_pkg::PLANES;

    // Configuration registers.
    logic       simultaneous_reg;
    logic       mask_enable_reg;
    logic [3:0] plane_select_reg;
    logic [7:0] mask_even_reg;
    logic [7:0] mask_odd_reg;
    logic [tvpw_pkg::DLINE_W-1:0] scroll_y_reg;

    // Captured transaction.
    logic             command_reg;
    logic [OFF_W-1:0] offset_reg;
    logic [1:0]       plane_reg;
    logic [7:0]       data_reg;

    logic [OFF_W-1:0] clr_cnt_reg;

    logic [7:0] old_byte [PLANES];
    logic [7:0] new_byte [PLANES];
    logic [7:0] fin_byte [PLANES];
    logic [PLANES-1:0] plane_we;
    logic [PLANES-1:0] plane_diff;
    logic [7:0] keep;
    logic       changed;
    logic [31:0] pixels;
    logic [tvpw_pkg::DLINE_W-1:0] line;
    logic [tvpw_pkg::DLINE_W-1:0] dline;
    logic [OFF_W-1:0] ram_waddr;
    tvpw_pkg::rsp_t rsp_reg, rsp_next;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            simultaneous_reg <= 1'b0;
            mask_enable_reg  <= 1'b0;
            plane_select_reg <= 4'd0;
            mask_even_reg    <= 8'd0;
            mask_odd_reg     <= 8'd0;
            scroll_y_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tvpw_pkg::CFG_SIMULTANEOUS: simultaneous_reg <= cfg_data[0];
                tvpw_pkg::CFG_MASK_ENABLE:  mask_enable_reg  <= cfg_data[0];
                tvpw_pkg::CFG_PLANE_SELECT: plane_select_reg <= cfg_data[3:0];
                tvpw_pkg::CFG_MASK_EVEN:    mask_even_reg    <= cfg_data[7:0];
                tvpw_pkg::CFG_MASK_ODD:     mask_odd_reg     <= cfg_data[7:0];
                tvpw_pkg::CFG_SCROLL_Y:     scroll_y_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Clearing pass counter, one offset of all planes per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == {OFF_W{1'b1}});

    // Transaction capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            command_reg <= req.command;
            offset_reg  <= req.address[OFF_W-1:0];
            plane_reg   <= req.address[OFF_W+1:OFF_W];
            data_reg    <= req.write_data;
        end
    end

    // Byte merge for every plane.
    assign keep = offset_reg[0] ? mask_odd_reg : mask_even_reg;

    always_comb
    begin
        for (int n = 0; n < PLANES; n++)
        begin
            plane_we[n] = (command_reg == tvpw_pkg::CMD_WRITE) &&
                          (simultaneous_reg ? plane_select_reg[n]
                                            : (plane_reg == 2'(n)));
            new_byte[n] = mask_enable_reg ? ((old_byte[n] & keep) | (data_reg & ~keep))
                                          : data_reg;
            plane_diff[n] = plane_we[n] && (new_byte[n] != old_byte[n]);
            fin_byte[n]   = plane_we[n] ? new_byte[n] : old_byte[n];
        end
    end

    assign changed   = |plane_diff;
    assign ram_waddr = cmd.clear ? clr_cnt_reg : offset_reg;

    // Plane memories.
    for (genvar g = 0; g < PLANES; g++)
    begin : g_plane
        tvpw_plane_ram u_ram (
            .clk   (clk),
            .we    (cmd.clear || (cmd.commit && plane_we[g])),
            .waddr (ram_waddr),
            .wdata (cmd.clear ? 8'd0 : new_byte[g]),
            .re    (cmd.read_en),
            .raddr (offset_reg),
            .rdata (old_byte[g])
        );
    end

    // Planar to chunky: pixel k takes bit 7-k of each plane.
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            for (int n = 0; n < PLANES; n++)
            begin
                pixels[4*k+n] = fin_byte[n][7-k];
            end
        end
    end

    // Dirty line relative to the scroll position.
    assign line  = tvpw_pkg::DLINE_W'(offset_reg >> 7) & tvpw_pkg::LINE_MASK;
    assign dline = (line - (scroll_y_reg & tvpw_pkg::LINE_MASK)) & tvpw_pkg::LINE_MASK;

    // Result assembly.
    always_comb
    begin
        rsp_next = '0;
        if (command_reg == tvpw_pkg::CMD_READ)
        begin
            rsp_next.read_data = old_byte[plane_reg];
        end
        else
        begin
            rsp_next.line_dirty   = changed;
            rsp_next.dirty_line   = changed ? dline : '0;
            rsp_next.pixels_valid = 1'b1;
            rsp_next.pixel_group  = tvpw_pkg::GROUP_W'(offset_reg);
            rsp_next.pixels       = pixels;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule
`default_nettype wire
